>>> rtl/assert_macros.svh
// Assertion macros used by the RTL files (included by the editor core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, used for properties that span sequencer steps.
`define ASSERT_GBL(label, prop, msg) \
  `ASSERT_CLK(label, prop, msg)

`endif

>>> rtl/gbl_pkg.sv
// Package: codes, widths and defaults of the gap buffer line editor.
package gbl_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_READ      = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BEYOND = 2'd3
  } status_t;

endpackage

>>> rtl/gbl_in_if.sv
// Edit request channel: valid/ready plus operation, column and byte.
interface gbl_in_if;
  logic                          valid;
  logic                          ready;
  logic [gbl_pkg::OP_W-1:0]      operation;
  logic [gbl_pkg::BYTE_W-1:0]    column;
  logic [gbl_pkg::BYTE_W-1:0]    char_in;

  modport source (output valid, operation, column, char_in, input ready);
  modport sink   (input valid, operation, column, char_in, output ready);
endinterface

>>> rtl/gbl_out_if.sv
// Result channel: valid/ready plus byte read, line length and status.
interface gbl_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbl_pkg::BYTE_W-1:0]    char_out;
  logic [gbl_pkg::BYTE_W-1:0]    line_length;
  logic [gbl_pkg::STAT_W-1:0]    status;

  modport source (output valid, char_out, line_length, status, input ready);
  modport sink   (input valid, char_out, line_length, status, output ready);
endinterface

>>> rtl/gap_buffer_line_editor_core.sv
// Gap buffer line editor: one request at a time, gap moved one byte per cycle.
// Steps after acceptance: read via S_RDREQ and S_RDWAIT; insert/backspace via S_MOVE, one byte
// per step up to the clamped column, then S_APPLY; refused, out-of-range and unused-opcode requests
// go straight to S_RESULT, which waits while an earlier result is still held; in ready only when
// idle, so a new request is taken only after the last result has been registered.
// Sync active-low reset: empty line, whole store is gap, no result pending; memory kept.
module gap_buffer_line_editor_core #(
  parameter int CAPACITY = gbl_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbl_in_if.sink    in_ch,
  gbl_out_if.source out_ch
);
  import gbl_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = $clog2(CAPACITY + 1);   // holds 0..CAPACITY
  localparam int AW = $clog2(CAPACITY);       // memory index
  localparam int XW = (PW > BYTE_W) ? PW : BYTE_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE, S_APPLY, S_RDREQ, S_RDWAIT, S_RESULT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PW-1:0]          gb_r, gb_nxt, gf_r, gf_nxt;
  logic [PW-1:0]          tgt_r, tgt_nxt;
  logic [AW-1:0]          phys_r, phys_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [BYTE_W-1:0]      ch_r, ch_nxt;
  logic [STAT_W-1:0]      res_st_r, res_st_nxt;
  logic [BYTE_W-1:0]      res_ch_r, res_ch_nxt;
  logic                   wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]          wr_addr_r, wr_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      char_out_r, char_out_nxt;
  logic [BYTE_W-1:0]      len_out_r, len_out_nxt;
  logic [STAT_W-1:0]      status_r, status_nxt;

  logic [BYTE_W-1:0]      mem [CAPACITY];
  logic [BYTE_W-1:0]      rd_data_r;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [BYTE_W-1:0]      wr_data;
  logic                   wr_en;

  logic [PW-1:0]          len, gb_dec, gf_dec, col_cl, phys_far;
  logic [XW-1:0]          col_x, len_x, col_cl_x, len_xo;

  assign len      = gb_r + (CAP_P - gf_r);
  assign gb_dec   = gb_r - 1'b1;
  assign gf_dec   = gf_r - 1'b1;
  assign col_x    = XW'(in_ch.column);
  assign len_x    = XW'(len);
  assign col_cl_x = (col_x > len_x) ? len_x : col_x;
  assign col_cl   = col_cl_x[PW-1:0];
  assign phys_far = col_cl + (gf_r - gb_r);
  assign len_xo   = XW'(len);

  // Memory ports: a move writes the byte read in the cycle before
  assign wr_en   = wr_pend_r || (state_r == S_APPLY && op_r == OP_INSERT);
  assign wr_addr = wr_pend_r ? wr_addr_r : gb_r[AW-1:0];
  assign wr_data = wr_pend_r ? rd_data_r : ch_r;

  always_comb begin
    if (state_r == S_MOVE && tgt_r < gb_r) begin
      rd_addr = gb_dec[AW-1:0];
    end else if (state_r == S_MOVE && tgt_r > gb_r) begin
      rd_addr = gf_r[AW-1:0];
    end else begin
      rd_addr = phys_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_out    = char_out_r;
  assign out_ch.line_length = len_out_r;
  assign out_ch.status      = status_r;

  always_comb begin
    state_nxt     = state_r;
    gb_nxt        = gb_r;
    gf_nxt        = gf_r;
    tgt_nxt       = tgt_r;
    phys_nxt      = phys_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    res_st_nxt    = res_st_r;
    res_ch_nxt    = res_ch_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    char_out_nxt  = char_out_r;
    len_out_nxt   = len_out_r;
    status_nxt    = status_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.operation;
          ch_nxt     = in_ch.char_in;
          tgt_nxt    = col_cl;
          phys_nxt   = (col_cl < gb_r) ? col_cl[AW-1:0] : phys_far[AW-1:0];
          res_st_nxt = ST_OK;
          res_ch_nxt = '0;
          case (in_ch.operation)
            OP_INSERT: begin
              if (len == CAP_P) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESULT;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            OP_BACKSPACE: begin
              if (col_cl == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RESULT;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            OP_READ: begin
              if (col_cl == len) begin
                res_st_nxt = ST_BEYOND;
                state_nxt  = S_RESULT;
              end else begin
                state_nxt = S_RDREQ;
              end
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_MOVE: begin
        if (tgt_r < gb_r) begin
          gb_nxt      = gb_dec;
          gf_nxt      = gf_dec;
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = gf_dec[AW-1:0];
        end else if (tgt_r > gb_r) begin
          gb_nxt      = gb_r + 1'b1;
          gf_nxt      = gf_r + 1'b1;
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = gb_r[AW-1:0];
        end else begin
          // last pending move write retires this cycle
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        gb_nxt    = (op_r == OP_INSERT) ? gb_r + 1'b1 : gb_dec;
        state_nxt = S_RESULT;
      end
      S_RDREQ:  state_nxt = S_RDWAIT;
      S_RDWAIT: begin
        res_ch_nxt = rd_data_r;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          char_out_nxt  = res_ch_r;
          len_out_nxt   = len_xo[BYTE_W-1:0];
          status_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gb_r        <= '0;
      gf_r        <= CAP_P;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gb_r        <= gb_nxt;
      gf_r        <= gf_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r      <= tgt_nxt;
    phys_r     <= phys_nxt;
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    res_st_r   <= res_st_nxt;
    res_ch_r   <= res_ch_nxt;
    wr_addr_r  <= wr_addr_nxt;
    char_out_r <= char_out_nxt;
    len_out_r  <= len_out_nxt;
    status_r   <= status_nxt;
  end

  `ASSERT_CLK(a_gap_order, (gb_r <= gf_r) && (gf_r <= CAP_P), "gap bounds out of order")
  `ASSERT_CLK(a_pend_in_move,
    wr_pend_r |-> (state_r == S_MOVE || state_r == S_APPLY), "move write outside gap move")
  `ASSERT_GBL(a_rise_from_result,
    $rose(out_valid_r) |-> $past(state_r == S_RESULT), "result without sequencer")
  `ASSERT_GBL(a_insert_grows,
    (state_r == S_APPLY && op_r == OP_INSERT) |=> (len == $past(len) + 1'b1),
    "insert did not grow line")
  `ASSERT_CLK(a_move_keeps_len, (state_r == S_MOVE) |=> (len == $past(len)), "gap move changed length")

endmodule
